[src/sftr_pkg.sv]
// Package: shared constants, types, font ROM and row helpers of the text rasterizer.
`default_nettype none
package sftr_pkg;

  localparam int SCALE       = 3;
  localparam int SPACING     = 2;
  localparam int FONT_W      = 5;
  localparam int FONT_H      = 7;
  localparam int GLYPHS      = 25;
  localparam int PITCH       = FONT_W * SCALE + SPACING;
  localparam int ROWS        = FONT_H * SCALE;
  localparam int MAX_CHARS_D = 64;

  localparam int CODE_W  = 8;
  localparam int X_W     = 11;
  localparam int ROW_W   = 5;
  localparam int PIX_W   = 15;
  localparam int GIDX_W  = 5;
  localparam int FROW_W  = 3;
  localparam int REP_W   = (SCALE > 1) ? $clog2(SCALE) : 1;

  localparam logic [GIDX_W-1:0] GLYPH_NONE = GIDX_W'(GLYPHS);

  localparam logic [FONT_W-1:0] FONT_ROM [0:GLYPHS-1][0:FONT_H-1] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    '{5'h06, 5'h09, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    '{5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h00, 5'h0E, 5'h0E, 5'h0E, 5'h00, 5'h00},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}
  };

  // One character after classification, waiting for the row generator.
  typedef struct packed {
    logic [GIDX_W-1:0] glyph;
    logic              known;
    logic              overflow;
    logic [X_W-1:0]    x_origin;
    logic [X_W-1:0]    text_width;
  } char_desc_t;

  typedef struct packed {
    logic       push;
    char_desc_t desc;
  } queue_wr_t;

  typedef struct packed {
    logic       valid;
    char_desc_t desc;
  } queue_rd_t;

  function automatic logic [GIDX_W-1:0] font_index(input logic [CODE_W-1:0] code);
    logic [GIDX_W-1:0] idx;
    begin
      if (code >= 8'h30 && code <= 8'h39) begin
        idx = GIDX_W'(code - 8'h30);
      end else begin
        case (code)
          8'h66:         idx = 5'd10;
          8'h70:         idx = 5'd11;
          8'h73, 8'h53:  idx = 5'd12;
          8'h4D:         idx = 5'd13;
          8'h6B:         idx = 5'd14;
          8'h55:         idx = 5'd15;
          8'h42:         idx = 5'd16;
          8'h57:         idx = 5'd17;
          8'h49:         idx = 5'd18;
          8'h46:         idx = 5'd19;
          8'h20:         idx = 5'd20;
          8'h2F:         idx = 5'd21;
          8'h4C:         idx = 5'd22;
          8'h41:         idx = 5'd23;
          8'h4E:         idx = 5'd24;
          default:       idx = GLYPH_NONE;
        endcase
      end
      return idx;
    end
  endfunction

  function automatic logic [FONT_W-1:0] font_row(input logic [GIDX_W-1:0] glyph,
                                                 input logic [FROW_W-1:0] frow);
    logic [FONT_W-1:0] bits;
    begin
      bits = '0;
      if (glyph < GLYPH_NONE && frow < FROW_W'(FONT_H)) begin
        bits = FONT_ROM[glyph][frow];
      end
      return bits;
    end
  endfunction

  // Each font bit is repeated SCALE times; the top font bit lands leftmost.
  function automatic logic [PIX_W-1:0] widen_bits(input logic [FONT_W-1:0] bits);
    logic [PIX_W-1:0] mask;
    begin
      mask = '0;
      for (int c = 0; c < FONT_W; c++) begin
        for (int k = 0; k < SCALE; k++) begin
          mask[PIX_W-1-(c*SCALE+k)] = bits[FONT_W-1-c];
        end
      end
      return mask;
    end
  endfunction

endpackage
`default_nettype wire

[src/sftr_if.sv]
// Interfaces: character input channel and pixel row output channel.
`default_nettype none
interface sftr_char_if import sftr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface sftr_row_if import sftr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [X_W-1:0]   x_origin;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] pixels;
  logic             glyph_known;
  logic             last_row;
  logic [X_W-1:0]   text_width;
  logic             overflow;

  modport source (output valid, output x_origin, output row, output pixels,
                  output glyph_known, output last_row, output text_width,
                  output overflow, input ready);
  modport sink   (input valid, input x_origin, input row, input pixels,
                  input glyph_known, input last_row, input text_width,
                  input overflow, output ready);
endinterface
`default_nettype wire

[src/sftr_front.sv]
// Front part: accepts characters, tracks text position and builds descriptors.
`default_nettype none
module sftr_front import sftr_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_D
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CODE_W-1:0] char_code,
  input  wire logic              end_of_text,
  input  wire logic              queue_full,
  output queue_wr_t              queue_wr
);

  localparam int POS_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int MUL_W = POS_W + 6;

  logic [POS_W-1:0]  char_position;
  logic [POS_W-1:0]  char_position_next;
  logic              overflow_seen;
  logic              overflow_seen_next;
  logic              take;
  logic [GIDX_W-1:0] glyph;
  logic [MUL_W-1:0]  x_full;
  logic [MUL_W-1:0]  w_full;
  logic              at_limit;

  assign in_ready = !queue_full;
  assign take     = in_valid && !queue_full;
  assign glyph    = font_index(char_code);
  assign at_limit = {1'b0, char_position} >= (POS_W+1)'(MAX_CHARS - 1);

  // Constant multiplies by the character pitch.
  assign x_full = MUL_W'(char_position) * MUL_W'(PITCH);
  assign w_full = x_full + MUL_W'(PITCH - SPACING);

  always_comb begin
    queue_wr.push                = take;
    queue_wr.desc.glyph          = glyph;
    queue_wr.desc.known          = glyph != GLYPH_NONE;
    queue_wr.desc.overflow       = overflow_seen;
    queue_wr.desc.x_origin       = x_full[X_W-1:0];
    queue_wr.desc.text_width     = end_of_text ? w_full[X_W-1:0] : '0;
  end

  always_comb begin
    char_position_next = char_position;
    overflow_seen_next = overflow_seen;
    if (take) begin
      if (end_of_text) begin
        char_position_next = '0;
        overflow_seen_next = 1'b0;
      end else if (at_limit) begin
        char_position_next = POS_W'(MAX_CHARS - 1);
        overflow_seen_next = 1'b1;
      end else begin
        char_position_next = char_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      overflow_seen <= 1'b0;
    end else begin
      char_position <= char_position_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule
`default_nettype wire

[src/sftr_queue.sv]
// Two-entry descriptor queue between the front and back parts.
`default_nettype none
module sftr_queue import sftr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  queue_wr_t      queue_wr,
  input  wire logic      pop,
  output logic           full,
  output queue_rd_t      queue_rd
);

  char_desc_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full           = count == 2'd2;
  assign queue_rd.valid = count != 2'd0;
  assign queue_rd.desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (queue_wr.push) begin
      entries[wr_ptr] <= queue_wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (queue_wr.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, queue_wr.push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[src/sftr_back.sv]
// Back part: walks the scaled rows of the head character into an output register.
`default_nettype none
module sftr_back import sftr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  queue_rd_t queue_rd,
  output logic      pop,
  sftr_row_if.source rows
);

  logic [FROW_W-1:0] frow;
  logic [REP_W-1:0]  rep;
  logic [ROW_W-1:0]  row_cnt;
  logic              out_valid;
  logic              load;
  logic              is_last;

  assign load    = queue_rd.valid && (!out_valid || rows.ready);
  assign is_last = (frow == FROW_W'(FONT_H - 1)) && (rep == REP_W'(SCALE - 1));
  assign pop     = load && is_last;

  assign rows.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      frow      <= '0;
      rep       <= '0;
      row_cnt   <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (is_last) begin
          frow    <= '0;
          rep     <= '0;
          row_cnt <= '0;
        end else begin
          row_cnt <= row_cnt + 1'b1;
          if (rep == REP_W'(SCALE - 1)) begin
            rep  <= '0;
            frow <= frow + 1'b1;
          end else begin
            rep <= rep + 1'b1;
          end
        end
      end else if (rows.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rows.x_origin    <= queue_rd.desc.x_origin;
      rows.row         <= row_cnt;
      rows.pixels      <= queue_rd.desc.known ?
                          widen_bits(font_row(queue_rd.desc.glyph, frow)) : '0;
      rows.glyph_known <= queue_rd.desc.known;
      rows.last_row    <= is_last;
      rows.text_width  <= is_last ? queue_rd.desc.text_width : '0;
      rows.overflow    <= queue_rd.desc.overflow;
    end
  end

endmodule
`default_nettype wire

[src/scaled_font_text_rasterizer_unit.sv]
// Top level: scaled 5x7 text rasterizer, one character in, 21 pixel rows out.
//
//   Channel | Direction | Payload
//   chars   | sink      | char_code[7:0], end_of_text
//   rows    | source    | x_origin[10:0], row[4:0], pixels[14:0], glyph_known,
//           |           | last_row, text_width[10:0], overflow
//
// Each character yields 21 row transfers, one per cycle while rows is not stalled;
// the row counter of the row generator sets the sustained rate.
// A new character is accepted whenever the two-entry descriptor queue has room,
// so the front runs ahead of the row generator.
// Reset (rst, synchronous) clears the position, the overflow flag, the queue
// and the output register. A stall on rows holds the output register and
// backs the queue up; chars.ready falls only when the queue is full.
`default_nettype none
module scaled_font_text_rasterizer_unit import sftr_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_D
) (
  input wire logic   clk,
  input wire logic   rst,
  sftr_char_if.sink  chars,
  sftr_row_if.source rows
);

  queue_wr_t queue_wr;
  queue_rd_t queue_rd;
  logic      queue_full;
  logic      pop;

  // The front classifies each character and fixes its place in the text.
  sftr_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (chars.valid),
    .in_ready    (chars.ready),
    .char_code   (chars.char_code),
    .end_of_text (chars.end_of_text),
    .queue_full  (queue_full),
    .queue_wr    (queue_wr)
  );

  // The queue lets the front take new characters while rows are still going out.
  sftr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .queue_wr (queue_wr),
    .pop      (pop),
    .full     (queue_full),
    .queue_rd (queue_rd)
  );

  // The back part emits one scaled row per cycle while rows is not stalled and frees the entry on the last.
  sftr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .queue_rd (queue_rd),
    .pop      (pop),
    .rows     (rows)
  );

endmodule
`default_nettype wire

[src/sftr_checker.sv]
// Checker: port-level properties of the rasterizer and its bind.
`default_nettype none
module sftr_checker import sftr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ROW_W-1:0] out_row,
  input wire logic [PIX_W-1:0] out_pixels,
  input wire logic             out_known,
  input wire logic             out_last,
  input wire logic [X_W-1:0]   out_width
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row))
    else $error("row transfer dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_row == ROW_W'(ROWS - 1))))
    else $error("last_row does not match the final row index");

  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_width == '0)
    else $error("text width shown before the last row");

  a_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_known |-> out_pixels == '0)
    else $error("unknown character produced lit pixels");

endmodule

bind scaled_font_text_rasterizer_unit sftr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rows.valid),
  .out_ready  (rows.ready),
  .out_row    (rows.row),
  .out_pixels (rows.pixels),
  .out_known  (rows.glyph_known),
  .out_last   (rows.last_row),
  .out_width  (rows.text_width)
);
`default_nettype wire
